FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; take in with `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsl_pkg.sv
// types, register indexes and reset constants of the button press detector
// no dependencies; used by every rtl module through scoped names
package bsl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_GUARD    = 2'd0,
    REG_MIN_PRESS     = 2'd1,
    REG_LONG_PRESS    = 2'd2,
    REG_TOGGLE_LOCK   = 2'd3
  } bsl_reg_idx_t;

  localparam logic [7:0]  EDGE_GUARD_RST  = 8'd4;
  localparam logic [15:0] MIN_PRESS_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd650;
  localparam logic [15:0] TOGGLE_LOCK_RST = 16'd90;

  // one input beat
  typedef struct packed {
    logic [31:0] now_ms;
    logic        raw_pressed;
    logic        edge_seen;
    logic        edge_level;
    logic [31:0] edge_time_ms;
  } bsl_in_t;

  // one result beat
  typedef struct packed {
    logic short_press;
    logic long_press;
  } bsl_out_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  edge_guard_ms;
    logic [15:0] min_press_ms;
    logic [15:0] long_press_ms;
    logic [15:0] toggle_lockout_ms;
  } bsl_cfg_t;

  // detector state carried from tick to tick
  typedef struct packed {
    logic        started;
    logic        last_level;
    logic [31:0] last_edge_time;
    logic        press_held;
    logic [31:0] press_start_time;
    logic        short_ready;
    logic        long_done;
    logic [31:0] last_short_time;
  } bsl_state_t;

endpackage

FILE: rtl/button_short_long_press.sv
// top level of the button short / long press detector
// depends on bsl_pkg, bsl_cfg_regs, bsl_step and assert_macros.svh
`include "assert_macros.svh"

// One input beat is one millisecond tick: the current time, the sampled
// button level and an optional edge record; each tick yields exactly one
// result beat with short_press and long_press flags. The first tick after
// reset only initializes the edge tracker and reports nothing. A beat is
// held in the input register, is evaluated against the detector state
// in a single pass, and its result is registered in the output register; a
// new beat is taken every cycle while out_ready is high; the output register
// stalls the input side only when both registers hold beats and out_ready
// is low. Time differences wrap modulo 2^32. Configuration writes take
// effect the cycle after cfg_we and are meant for when no beat is in flight.
module button_short_long_press (
  input  logic                            clk,
  input  logic                            rst_n,
  // input tick channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsl_pkg::bsl_in_t                in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsl_pkg::bsl_out_t               out_data,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [bsl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bsl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  bsl_pkg::bsl_cfg_t   cfg;

  // input register
  logic                stg_vld_r;
  bsl_pkg::bsl_in_t    stg_r;

  // detector state
  bsl_pkg::bsl_state_t state_r;
  bsl_pkg::bsl_state_t state_nxt;

  // result register
  logic                out_vld_r;
  bsl_pkg::bsl_out_t   out_r;
  bsl_pkg::bsl_out_t   res;

  logic                adv;

  bsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsl_step u_step (
    .beat (stg_r),
    .cfg  (cfg),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // the staged beat moves on whenever the result slot is free or draining
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_r <= in_data;
    end
  end

  // state only moves when a staged beat is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (stg_vld_r && adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stg_vld_r) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // a tick never reports a long press and a short press together
  `ASSERT_IMPLIES(a_one_event, clk, rst_n, out_vld_r, !(out_r.short_press && out_r.long_press), "both press events on one beat")

  // the initializing tick is silent
  `ASSERT_NEXT(a_first_quiet, clk, rst_n, adv && stg_vld_r && !state_r.started, out_vld_r && (out_r == '0), "first tick reported an event")

  // a short press always ends the held press
  `ASSERT_NEXT(a_short_ends, clk, rst_n, adv && stg_vld_r && res.short_press, !state_r.press_held && !state_r.short_ready, "short press left press held")

  // a long press marks the press as done
  `ASSERT_NEXT(a_long_marks, clk, rst_n, adv && stg_vld_r && res.long_press, state_r.long_done && state_r.press_held, "long press not recorded")

endmodule

FILE: rtl/bsl_cfg_regs.sv
// configuration register file of the button press detector
// depends on bsl_pkg
module bsl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bsl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bsl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output bsl_pkg::bsl_cfg_t               cfg
);

  bsl_pkg::bsl_cfg_t cfg_r;
  bsl_pkg::bsl_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        bsl_pkg::REG_EDGE_GUARD:  cfg_nxt.edge_guard_ms     = cfg_wdata[7:0];
        bsl_pkg::REG_MIN_PRESS:   cfg_nxt.min_press_ms      = cfg_wdata;
        bsl_pkg::REG_LONG_PRESS:  cfg_nxt.long_press_ms     = cfg_wdata;
        bsl_pkg::REG_TOGGLE_LOCK: cfg_nxt.toggle_lockout_ms = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_guard_ms     <= bsl_pkg::EDGE_GUARD_RST;
      cfg_r.min_press_ms      <= bsl_pkg::MIN_PRESS_RST;
      cfg_r.long_press_ms     <= bsl_pkg::LONG_PRESS_RST;
      cfg_r.toggle_lockout_ms <= bsl_pkg::TOGGLE_LOCK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/bsl_step.sv
// next-state and result logic for one tick of the button press detector
// purely combinational; depends on bsl_pkg
module bsl_step (
  input  bsl_pkg::bsl_in_t    beat,
  input  bsl_pkg::bsl_cfg_t   cfg,
  input  bsl_pkg::bsl_state_t cur,
  output bsl_pkg::bsl_state_t nxt,
  output bsl_pkg::bsl_out_t   res
);

  bsl_pkg::bsl_state_t trk;
  logic [31:0] held;
  logic [31:0] edge_age;
  logic [31:0] short_age;

  // edge tracker first: guard check below sees the updated edge time
  always_comb begin
    trk = cur;
    if (beat.edge_seen) begin
      trk.last_level     = beat.edge_level;
      trk.last_edge_time = beat.edge_time_ms;
    end
    if (!cur.started) begin
      trk.started        = 1'b1;
      trk.last_level     = beat.raw_pressed;
      trk.last_edge_time = beat.now_ms;
    end else if (!beat.edge_seen && (beat.raw_pressed != trk.last_level)) begin
      trk.last_level     = beat.raw_pressed;
      trk.last_edge_time = beat.now_ms;
    end
  end

  // press start time after a new press latches
  assign held      = beat.now_ms - (cur.press_held ? cur.press_start_time : beat.now_ms);
  assign edge_age  = beat.now_ms - trk.last_edge_time;
  assign short_age = beat.now_ms - cur.last_short_time;

  always_comb begin
    nxt = trk;
    res = '0;
    if (cur.started) begin
      if (beat.raw_pressed) begin
        if (!cur.press_held) begin
          nxt.press_held       = 1'b1;
          nxt.press_start_time = beat.now_ms;
          nxt.short_ready      = 1'b0;
          nxt.long_done        = 1'b0;
        end
        if (held >= {16'd0, cfg.min_press_ms}) begin
          nxt.short_ready = 1'b1;
        end
        if (!nxt.long_done && (held >= {16'd0, cfg.long_press_ms})) begin
          nxt.long_done   = 1'b1;
          nxt.short_ready = 1'b0;
          res.long_press  = 1'b1;
        end
      end else if (cur.press_held && (edge_age >= {24'd0, cfg.edge_guard_ms})) begin
        nxt.press_held = 1'b0;
        if (!cur.long_done && cur.short_ready &&
            (short_age >= {16'd0, cfg.toggle_lockout_ms})) begin
          nxt.last_short_time = beat.now_ms;
          nxt.short_ready     = 1'b0;
          res.short_press     = 1'b1;
        end
      end
    end
  end

endmodule
